// ===== design/cpf_pkg.sv =====
// shared types and constants of the command packet framer
package cpf_pkg;

  // largest parameter count honored on a begin request; larger counts are clamped
  localparam logic [7:0] MAX_PARAMS = 8'd255;

  localparam logic [15:0] HEADER_WORD_RST = 16'hEF01;
  localparam logic [31:0] MODULE_ADDR_RST = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic REG_HEADER_WORD = 1'b0;
  localparam logic REG_MODULE_ADDR = 1'b1;

  // request actions
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_PARAM = 1'b1;

  // how the held request is expanded into bytes
  localparam logic [2:0] KIND_BEGIN_OPEN  = 3'd0;  // header through command, packet stays open
  localparam logic [2:0] KIND_BEGIN_CLOSE = 3'd1;  // header through command plus checksum
  localparam logic [2:0] KIND_PARAM       = 3'd2;  // one parameter byte
  localparam logic [2:0] KIND_PARAM_CLOSE = 3'd3;  // last parameter byte plus checksum
  localparam logic [2:0] KIND_STRAY       = 3'd4;  // parameter with no packet open

  // byte positions within a begin request
  localparam logic [3:0] POS_CMD    = 4'd9;
  localparam logic [3:0] POS_SUM_LO = 4'd11;
  // byte positions within a closing parameter request
  localparam logic [3:0] POS_PSUM_LO = 4'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  pkt_type;
    logic [7:0]  command;
    logic [15:0] length;
    logic [7:0]  param_byte;
    logic [15:0] sum;
  } cpf_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       frame_end;
    logic       stray;
  } cpf_beat_t;

endpackage

// ===== design/cpf_byte_sel.sv =====
// picks the byte and its flags at one position of a held request
module cpf_byte_sel (
  input  cpf_pkg::cpf_item_t item,
  input  logic [3:0]         pos,
  input  logic [15:0]        header_word,
  input  logic [31:0]        module_addr,
  output cpf_pkg::cpf_beat_t beat
);

  logic [7:0] begin_byte;

  always_comb begin
    case (pos)
      4'd0:    begin_byte = header_word[15:8];
      4'd1:    begin_byte = header_word[7:0];
      4'd2:    begin_byte = module_addr[31:24];
      4'd3:    begin_byte = module_addr[23:16];
      4'd4:    begin_byte = module_addr[15:8];
      4'd5:    begin_byte = module_addr[7:0];
      4'd6:    begin_byte = item.pkt_type;
      4'd7:    begin_byte = item.length[15:8];
      4'd8:    begin_byte = item.length[7:0];
      4'd9:    begin_byte = item.command;
      4'd10:   begin_byte = item.sum[15:8];
      default: begin_byte = item.sum[7:0];
    endcase
  end

  always_comb begin
    beat = '0;
    case (item.kind)
      cpf_pkg::KIND_BEGIN_OPEN: begin
        beat.data = begin_byte;
        beat.last = (pos == cpf_pkg::POS_CMD);
      end
      cpf_pkg::KIND_BEGIN_CLOSE: begin
        beat.data      = begin_byte;
        beat.last      = (pos == cpf_pkg::POS_SUM_LO);
        beat.frame_end = (pos == cpf_pkg::POS_SUM_LO);
      end
      cpf_pkg::KIND_PARAM: begin
        beat.data = item.param_byte;
        beat.last = 1'b1;
      end
      cpf_pkg::KIND_PARAM_CLOSE: begin
        case (pos)
          4'd0:    beat.data = item.param_byte;
          4'd1:    beat.data = item.sum[15:8];
          default: beat.data = item.sum[7:0];
        endcase
        beat.last      = (pos == cpf_pkg::POS_PSUM_LO);
        beat.frame_end = (pos == cpf_pkg::POS_PSUM_LO);
      end
      default: begin
        beat.data  = 8'd0;
        beat.last  = 1'b1;
        beat.stray = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/command_packet_framer_unit.sv =====
// top level of the command packet framer: request intake, packet state and byte output
// Turns begin and parameter requests into the byte stream of a sensor command packet.
// A begin request sends the header word (high byte first), the 4-byte device address
// (most significant first), the type, a 16-bit length equal to the parameter count plus 3
// and the command; with a count of zero the 16-bit checksum follows at once. Each
// parameter request sends its byte, and the one that completes the packet adds the
// checksum high and low bytes (the low byte carries frame_end). The checksum is the
// wrapping 16-bit sum of type, length, command and all parameter bytes. A begin drops
// any open packet; a parameter with no packet open gives one zero byte with stray_param.
// Counts above MAX_PARAMS are clamped. Packet state is updated as a request is taken;
// one held request is expanded into one byte per cycle, unless m_tready stalls, into the
// output register; a begin request gives 10 or 12 bytes and a parameter request 1 or 3.
// The byte rate at the output is one per cycle without a stall, and the next request is
// taken in the cycle its predecessor's last byte moves to the output register.
module command_packet_framer_unit #(
  parameter logic [7:0] MAX_PARAMS = cpf_pkg::MAX_PARAMS
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pkt_type[7:0], command[15:8], param_count[23:16],
                                 // param_byte[31:24]
  input  logic        s_tuser,   // action: 0 begin, 1 parameter byte
  // byte stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,   // run_last: last byte caused by one request
  output logic [1:0]  m_tuser,   // frame_end[0], stray_param[1]
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [15:0] header_word;
  logic [31:0] module_addr;

  // packet state
  logic        frame_open;
  logic [7:0]  params_left;
  logic [15:0] running_sum;

  // held request
  logic               item_valid;
  cpf_pkg::cpf_item_t item;
  logic [3:0]         pos;

  // request fields
  logic       in_action;
  logic [7:0] in_type;
  logic [7:0] in_cmd;
  logic [7:0] in_count;
  logic [7:0] in_pbyte;

  logic               item_load;
  logic               out_load;
  logic               emit;
  cpf_pkg::cpf_item_t item_next;
  cpf_pkg::cpf_beat_t beat;

  logic        frame_open_next;
  logic [7:0]  params_left_next;
  logic [7:0]  count_clamped;
  logic [15:0] length;

  assign in_action = s_tuser;
  assign in_type   = s_tdata[7:0];
  assign in_cmd    = s_tdata[15:8];
  assign in_count  = s_tdata[23:16];
  assign in_pbyte  = s_tdata[31:24];

  // handshake: the output register frees when empty or taken, the held request
  // frees with its last byte
  assign out_load  = !m_tvalid || m_tready;
  assign emit      = item_valid && out_load;
  assign s_tready  = !item_valid || (emit && beat.last);
  assign item_load = s_tvalid && s_tready;

  // clamp count and build length
  assign count_clamped = (in_count > MAX_PARAMS) ? MAX_PARAMS : in_count;
  assign length        = {8'd0, count_clamped} + 16'd3;

  // classify the request and advance packet state
  always_comb begin
    item_next            = '0;
    item_next.pkt_type   = in_type;
    item_next.command    = in_cmd;
    item_next.length     = length;
    item_next.param_byte = in_pbyte;
    frame_open_next      = frame_open;
    params_left_next     = params_left;
    item_next.sum        = running_sum;
    if (in_action == cpf_pkg::ACT_BEGIN) begin
      item_next.sum = length + {8'd0, in_type} + {8'd0, in_cmd};
      if (count_clamped == 8'd0) begin
        item_next.kind   = cpf_pkg::KIND_BEGIN_CLOSE;
        frame_open_next  = 1'b0;
        params_left_next = 8'd0;
      end else begin
        item_next.kind   = cpf_pkg::KIND_BEGIN_OPEN;
        frame_open_next  = 1'b1;
        params_left_next = count_clamped;
      end
    end else if (!frame_open || params_left == 8'd0) begin
      item_next.kind = cpf_pkg::KIND_STRAY;
    end else begin
      item_next.sum = running_sum + {8'd0, in_pbyte};
      if (params_left == 8'd1) begin
        item_next.kind   = cpf_pkg::KIND_PARAM_CLOSE;
        frame_open_next  = 1'b0;
        params_left_next = 8'd0;
      end else begin
        item_next.kind   = cpf_pkg::KIND_PARAM;
        params_left_next = params_left - 8'd1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_word <= cpf_pkg::HEADER_WORD_RST;
      module_addr <= cpf_pkg::MODULE_ADDR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cpf_pkg::REG_HEADER_WORD: header_word <= cfg_data[15:0];
        cpf_pkg::REG_MODULE_ADDR: module_addr <= cfg_data;
        default: ;
      endcase
    end
  end

  // packet state, updated as each request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      params_left <= 8'd0;
      running_sum <= 16'd0;
    end else if (item_load) begin
      frame_open  <= frame_open_next;
      params_left <= params_left_next;
      running_sum <= item_next.sum;
    end
  end

  // held request and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      pos        <= 4'd0;
    end else if (item_load) begin
      item_valid <= 1'b1;
      pos        <= 4'd0;
    end else if (emit) begin
      if (beat.last) begin
        item_valid <= 1'b0;
      end
      pos <= pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item <= item_next;
    end
  end

  cpf_byte_sel u_byte_sel (
    .item        (item),
    .pos         (pos),
    .header_word (header_word),
    .module_addr (module_addr),
    .beat        (beat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= beat.data;
      m_tlast <= beat.last;
      m_tuser <= {beat.stray, beat.frame_end};
    end
  end

  // an open packet always expects at least one more parameter
  a_open_has_params: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> params_left != 8'd0)
    else $error("open packet with no parameters left");

  // a stray byte is a zero byte that ends its request and closes no packet
  a_stray_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 8'd0 && !m_tuser[0])
    else $error("malformed stray parameter byte");

  // the closing checksum byte always ends its request
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("frame end not on last byte of request");

  // a taken request is held until its bytes go out
  a_take_holds: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> item_valid && pos == 4'd0)
    else $error("taken request not held");

endmodule
